@@ rtl/core/text_console_cursor_scroll_core_assert.svh @@
// Assertion macros for the text console core checker.
// Each macro expands to one labeled concurrent assertion clocked on clk, reset by arst_n.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_CORE_ASSERT_SVH

// same-cycle implication
`define TCCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TCCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/tccs_pkg.sv @@
// Shared types and constants for the text console core.
// No dependencies; imported by the controller, datapath, top level and checker.
`timescale 1ns / 1ps

package tccs_pkg;

	localparam int ROWS_DEF = 25;
	localparam int COLS_DEF = 80;

	localparam int ACT_W      = 2;
	localparam int CHAR_W     = 8;
	localparam int COLOR_W    = 8;
	localparam int RD_ROW_W   = 5;
	localparam int RD_COL_W   = 7;
	localparam int CUR_ROW_W  = 5;
	localparam int CUR_COL_W  = 7;
	localparam int CELL_W     = CHAR_W + COLOR_W;

	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

	localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'd32;
	localparam logic [CHAR_W-1:0]  PRINT_LOW    = 8'd32;
	localparam logic [CHAR_W-1:0]  PRINT_HIGH   = 8'd126;
	localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd7;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_SCROLL,
		ST_DONE
	} tccs_state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;       // input word taken this edge
		logic fill_all;     // blank the whole store, one cell per cycle
		logic fill_init;    // use the reset color for blanks
		logic fill_row;     // blank the row being scrolled in
		logic put_pending;  // commit the write held over a scroll
		logic out_load;     // load the output register
	} tccs_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic act_clear;
		logic read_hit;
		logic scroll_need;
		logic sweep_last_all;
		logic sweep_last_row;
	} tccs_stat_t;

endpackage

@@ rtl/core/tccs_ctrl.sv @@
// Controller FSM: handshakes, sweep sequencing and output valid.
// Depends on tccs_pkg; drives tccs_dp through tccs_cmd_t.
`timescale 1ns / 1ps

module tccs_ctrl import tccs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  tccs_stat_t stat,
	output tccs_cmd_t  cmd
);

	tccs_state_t state_q, state_nx;
	logic        out_valid_q;
	logic        out_free;
	logic        accept;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == ST_IDLE) && out_free);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (stat.sweep_last_all) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					priority if (stat.act_clear)   state_nx = ST_CLEAR;
					else if (stat.scroll_need)     state_nx = ST_SCROLL;
					else if (stat.read_hit)        state_nx = ST_DONE;
					else                           state_nx = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				if (stat.sweep_last_all) state_nx = ST_DONE;
			end
			ST_SCROLL: begin
				if (stat.sweep_last_row) state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_INIT;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.fill_all  = 1'b1;
				cmd.fill_init = 1'b1;
			end
			ST_IDLE: begin
				cmd.accept   = accept;
				cmd.out_load = accept && !stat.act_clear && !stat.scroll_need
					&& !stat.read_hit;
			end
			ST_CLEAR: begin
				cmd.fill_all = 1'b1;
			end
			ST_SCROLL: begin
				cmd.fill_row = 1'b1;
			end
			ST_DONE: begin
				cmd.put_pending = 1'b1;
				cmd.out_load    = out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/tccs_dp.sv @@
// Datapath: cell store, cursor and ring base, sweep counter, output register.
// Depends on tccs_pkg; commanded by tccs_ctrl.
`timescale 1ns / 1ps

module tccs_dp import tccs_pkg::*; #(
	parameter int ROWS = ROWS_DEF,
	parameter int COLS = COLS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tccs_cmd_t            cmd,
	output tccs_stat_t           stat,
	input  logic                 cfg_we,
	input  logic [COLOR_W-1:0]   cfg_data,
	input  logic [ACT_W-1:0]     action,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic [RD_ROW_W-1:0]  read_row,
	input  logic [RD_COL_W-1:0]  read_col,
	output logic [CHAR_W-1:0]    cell_char,
	output logic [COLOR_W-1:0]   cell_color,
	output logic [CUR_ROW_W-1:0] cursor_row,
	output logic [CUR_COL_W-1:0] cursor_col
);

	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLS);
	localparam int CCW   = $clog2(COLS + 1);
	localparam int AW    = RW + CW;
	localparam int DEPTH = ROWS * (2 ** CW);

	localparam logic [RW-1:0]  ROW_LAST = RW'(ROWS - 1);
	localparam logic [CCW-1:0] COL_END  = CCW'(COLS);
	localparam logic [CW-1:0]  COL_LAST = CW'(COLS - 1);
	localparam logic [AW-1:0]  ADDR_LAST = AW'(DEPTH - 1);

	// logical row to physical row under the ring base
	function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lr,
			input logic [RW-1:0] b);
		logic [RW:0] s;
		s = {1'b0, lr} + {1'b0, b};
		if (s >= (RW+1)'(ROWS)) s = s - (RW+1)'(ROWS);
		return s[RW-1:0];
	endfunction

	logic [CELL_W-1:0]  mem [DEPTH];
	logic [CELL_W-1:0]  rdata_q;

	logic [COLOR_W-1:0] color_q;
	logic [RW-1:0]      row_q;
	logic [CCW-1:0]     col_q;
	logic [RW-1:0]      base_q;
	logic [RW-1:0]      scroll_row_q;
	logic [AW-1:0]      sw_q;

	logic               pend_wr_q;
	logic               pend_read_q;
	logic [AW-1:0]      pend_addr_q;
	logic [CELL_W-1:0]  pend_data_q;

	logic [CHAR_W-1:0]    out_char_q;
	logic [COLOR_W-1:0]   out_color_q;
	logic [CUR_ROW_W-1:0] out_row_q;
	logic [CUR_COL_W-1:0] out_col_q;

	logic              is_wr, is_clr, is_rd;
	logic              is_nl, printable, wrap, row_inc, scroll;
	logic [RW-1:0]     new_row, base_new;
	logic [CCW-1:0]    col_base, new_col;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [CELL_W-1:0] wr_cell;
	logic              read_hit;
	logic              store_char;

	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [CELL_W-1:0] mem_wd;
	logic [COLOR_W-1:0] blank_color;

	logic [RW-1:0]     row_nx;
	logic [CCW-1:0]    col_nx;

	assign is_wr  = (action == ACT_WRITE);
	assign is_clr = (action == ACT_CLEAR);
	assign is_rd  = (action == ACT_READ);

	// cursor move for a character word
	assign is_nl     = (char_code == NEWLINE_CODE);
	assign printable = (char_code >= PRINT_LOW) && (char_code <= PRINT_HIGH);
	assign wrap      = !is_nl && (col_q >= COL_END);
	assign row_inc   = is_nl || wrap;
	assign scroll    = is_wr && row_inc && (row_q == ROW_LAST);
	assign new_row   = scroll ? ROW_LAST : (row_inc ? row_q + RW'(1) : row_q);
	assign base_new  = scroll ? ((base_q == ROW_LAST) ? '0 : base_q + RW'(1)) : base_q;
	assign col_base  = row_inc ? '0 : col_q;
	assign new_col   = is_nl ? '0 : col_base + CCW'(1);
	assign wr_addr   = {phys_row(new_row, base_new), col_base[CW-1:0]};
	assign wr_cell   = {color_q, char_code};
	assign store_char = is_wr && !is_nl && printable;

	assign read_hit = is_rd && (32'(read_row) < ROWS) && (32'(read_col) < COLS);
	assign rd_addr  = {phys_row(RW'(read_row), base_q), CW'(read_col)};

	assign stat.act_clear      = is_clr;
	assign stat.read_hit       = read_hit;
	assign stat.scroll_need    = scroll;
	assign stat.sweep_last_all = (sw_q == ADDR_LAST);
	assign stat.sweep_last_row = (sw_q[CW-1:0] == COL_LAST);

	assign blank_color = cmd.fill_init ? RESET_COLOR : color_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = pend_addr_q;
		mem_wd = pend_data_q;
		priority if (cmd.fill_all) begin
			mem_we = 1'b1;
			mem_wa = sw_q;
			mem_wd = {blank_color, BLANK_CODE};
		end else if (cmd.fill_row) begin
			mem_we = 1'b1;
			mem_wa = {scroll_row_q, sw_q[CW-1:0]};
			mem_wd = {color_q, BLANK_CODE};
		end else if (cmd.put_pending) begin
			mem_we = pend_wr_q;
		end else if (cmd.accept) begin
			mem_we = store_char && !scroll;
			mem_wa = wr_addr;
			mem_wd = wr_cell;
		end else begin
			mem_we = 1'b0;
		end
	end

	// cursor seen by the output register
	always_comb begin
		row_nx = row_q;
		col_nx = col_q;
		if (cmd.accept && is_wr) begin
			row_nx = new_row;
			col_nx = new_col;
		end else if (cmd.accept && is_clr) begin
			row_nx = '0;
			col_nx = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (cmd.accept && read_hit) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q      <= RESET_COLOR;
			row_q        <= '0;
			col_q        <= '0;
			base_q       <= '0;
			scroll_row_q <= '0;
			sw_q         <= '0;
			pend_wr_q    <= 1'b0;
			pend_read_q  <= 1'b0;
		end else begin
			if (cfg_we) color_q <= cfg_data;
			row_q <= row_nx;
			col_q <= col_nx;
			if (cmd.accept) begin
				sw_q        <= '0;
				pend_wr_q   <= store_char && scroll;
				pend_read_q <= read_hit;
				if (is_wr) begin
					base_q       <= base_new;
					scroll_row_q <= base_q;
				end else if (is_clr) begin
					base_q <= '0;
				end
			end else if (cmd.fill_all || cmd.fill_row) begin
				sw_q <= sw_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pend_addr_q <= wr_addr;
			pend_data_q <= wr_cell;
		end
		if (cmd.out_load) begin
			if (!cmd.accept && pend_read_q) begin
				out_char_q  <= rdata_q[CHAR_W-1:0];
				out_color_q <= rdata_q[CELL_W-1:CHAR_W];
			end else begin
				out_char_q  <= '0;
				out_color_q <= '0;
			end
			out_row_q <= CUR_ROW_W'(row_nx);
			out_col_q <= CUR_COL_W'(col_nx);
		end
	end

	assign cell_char  = out_char_q;
	assign cell_color = out_color_q;
	assign cursor_row = out_row_q;
	assign cursor_col = out_col_q;

endmodule

@@ rtl/core/text_console_cursor_scroll_core.sv @@
// Text console core: ROWS x COLS cell store, cursor, scroll and clear.
// A plain character or other word gives its result in the cycle after it is taken. An in-range
// read passes ST_DONE, a scroll ST_SCROLL then ST_DONE, a clear ST_CLEAR then ST_DONE.
// Throughput: a plain word every cycle while the result word is not stalled; reads, scrolls and
// clears hold the input until their result word is loaded.
// Reset: cursor home, color 7, then a blanking pass over ROWS*2^ceil(log2(COLS)) cells.
`timescale 1ns / 1ps

module text_console_cursor_scroll_core import tccs_pkg::*; #(
	parameter int ROWS = ROWS_DEF,
	parameter int COLS = COLS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration: default color
	input  logic                 cfg_we,
	input  logic [COLOR_W-1:0]   cfg_data,
	// input words
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [ACT_W-1:0]     action,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic [RD_ROW_W-1:0]  read_row,
	input  logic [RD_COL_W-1:0]  read_col,
	// result words
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CHAR_W-1:0]    cell_char,
	output logic [COLOR_W-1:0]   cell_color,
	output logic [CUR_ROW_W-1:0] cursor_row,
	output logic [CUR_COL_W-1:0] cursor_col
);

	// Scrolling rotates a ring base over the physical rows, so only the
	// row coming in at the bottom is blanked. A character that lands in
	// that row is held and written once the blanking sweep is done.
	// Reads go through a registered memory port, hence the extra ST_DONE state.

	tccs_cmd_t  cmd;
	tccs_stat_t stat;

	tccs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	tccs_dp #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.action     (action),
		.char_code  (char_code),
		.read_row   (read_row),
		.read_col   (read_col),
		.cell_char  (cell_char),
		.cell_color (cell_color),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col)
	);

endmodule

@@ rtl/core/tccs_checker.sv @@
// Port-level checker for the text console core, bound to the top level.
// Depends on tccs_pkg and text_console_cursor_scroll_core_assert.svh.
`timescale 1ns / 1ps
`include "text_console_cursor_scroll_core_assert.svh"

module tccs_checker import tccs_pkg::*; #(
	parameter int ROWS = ROWS_DEF,
	parameter int COLS = COLS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [CHAR_W-1:0]    cell_char,
	input logic [COLOR_W-1:0]   cell_color,
	input logic [CUR_ROW_W-1:0] cursor_row,
	input logic [CUR_COL_W-1:0] cursor_col
);

	`TCCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(cell_char) && $stable(cell_color)
		&& $stable(cursor_row) && $stable(cursor_col),
		"stalled result word changed")

	`TCCS_ASSERT_NOW(a_in_blocked, in_valid && out_valid && out_stall, in_stall,
		"input word taken while the result word is stalled")

	`TCCS_ASSERT_NOW(a_row_range, out_valid, 32'(cursor_row) < ROWS,
		"cursor row beyond last row")

	`TCCS_ASSERT_NOW(a_col_range, out_valid, 32'(cursor_col) <= COLS,
		"cursor column beyond wrap point")

	`TCCS_ASSERT_NOW(a_cell_printable, out_valid && (cell_char != '0),
		(cell_char >= PRINT_LOW) && (cell_char <= PRINT_HIGH),
		"read cell holds an unprintable code")

endmodule

bind text_console_cursor_scroll_core tccs_checker #(
	.ROWS (ROWS),
	.COLS (COLS)
) u_tccs_checker (.*);
